// ===== src/bced_pkg.sv =====
// Shared types and constants of the button click event detector.
`default_nettype none

package bced_pkg;

   // Per-button debounce and click phase.
   typedef enum logic [1:0] {
      PH_IDLE         = 2'd0,
      PH_DEBOUNCE     = 2'd1,
      PH_WAIT_RELEASE = 2'd2,
      PH_WAIT_SECOND  = 2'd3
   } phase_type;

   // Bit positions inside the event enable register.
   localparam int EV_LONG_BIT   = 0;
   localparam int EV_DOUBLE_BIT = 1;
   localparam int EV_SINGLE_BIT = 2;

   // Configuration register indexes.
   localparam logic [2:0] CSR_EVENT_ENABLE  = 3'd0;
   localparam logic [2:0] CSR_LONG_PRESS_MS = 3'd1;
   localparam logic [2:0] CSR_DOUBLE_GAP_MS = 3'd2;
   localparam logic [2:0] CSR_DEBOUNCE_MS   = 3'd3;
   localparam logic [2:0] CSR_ENABLED_COUNT = 3'd4;

   // Configuration reset values.
   localparam logic [2:0]  RST_EVENT_ENABLE  = 3'd7;
   localparam logic [15:0] RST_LONG_PRESS_MS = 16'd1000;
   localparam logic [15:0] RST_DOUBLE_GAP_MS = 16'd300;
   localparam logic [7:0]  RST_DEBOUNCE_MS   = 8'd20;
   localparam logic [3:0]  RST_ENABLED_COUNT = 4'd8;

   // Pins carried by one request.
   localparam int PINS = 8;

   // Request payload: one update tick.
   typedef struct packed {
      logic [31:0] now_ms;
      logic [7:0]  pin_levels;
   } req_type;

   // Response payload: events of one tick.
   typedef struct packed {
      logic [7:0] click_mask;
      logic [7:0] double_mask;
      logic [7:0] long_mask;
      logic [7:0] pressed_mask;
   } rsp_type;

   // Timing and enable settings shared by all buttons.
   typedef struct packed {
      logic [2:0]  event_enable;
      logic [15:0] long_press_ms;
      logic [15:0] double_gap_ms;
      logic [7:0]  debounce_ms;
   } cfg_type;

   // Events produced by one button in one tick.
   typedef struct packed {
      logic single_click;
      logic double_click;
      logic long_press;
   } event_type;

endpackage

`default_nettype wire

// ===== src/bced_button.sv =====
// State machine and time stamps of one button.
`default_nettype none

module bced_button
   import bced_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        step,
   input  wire logic        down,
   input  wire logic [31:0] now_ms,
   input  wire cfg_type     cfg,
   output event_type        events,
   output logic             level_next
);

   phase_type   phase_ff, phase_in;
   logic        level_ff;
   logic [31:0] press_stamp_ff;
   logic [31:0] release_stamp_ff;

   logic [31:0] held_ms;
   logic [31:0] gap_ms;
   logic        debounced;
   logic        long_hit;
   logic        gap_over;
   logic        capture_press;
   logic        capture_release;

   // Modular elapsed times and threshold compares.
   assign held_ms   = now_ms - press_stamp_ff;
   assign gap_ms    = now_ms - release_stamp_ff;
   assign debounced = held_ms >= {24'd0, cfg.debounce_ms};
   assign long_hit  = cfg.event_enable[EV_LONG_BIT] && (held_ms >= {16'd0, cfg.long_press_ms});
   assign gap_over  = gap_ms > {16'd0, cfg.double_gap_ms};

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            if (down) phase_in = PH_DEBOUNCE;
         end
         PH_DEBOUNCE: begin
            if (!down) phase_in = PH_IDLE;
            else if (debounced) phase_in = PH_WAIT_RELEASE;
         end
         PH_WAIT_RELEASE: begin
            if (!down) begin
               if (long_hit) phase_in = PH_IDLE;
               else if (cfg.event_enable[EV_DOUBLE_BIT]) phase_in = PH_WAIT_SECOND;
               else phase_in = PH_IDLE;
            end
         end
         PH_WAIT_SECOND: begin
            if (down) phase_in = PH_DEBOUNCE;
            else if (gap_over) phase_in = PH_IDLE;
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   // Events and time stamp captures.
   always_comb begin
      events          = '0;
      capture_press   = 1'b0;
      capture_release = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            capture_press = down;
         end
         PH_DEBOUNCE: begin
         end
         PH_WAIT_RELEASE: begin
            if (!down) begin
               capture_release = 1'b1;
               if (long_hit) events.long_press = 1'b1;
               else if (!cfg.event_enable[EV_DOUBLE_BIT])
                  events.single_click = cfg.event_enable[EV_SINGLE_BIT];
            end
         end
         PH_WAIT_SECOND: begin
            if (down) begin
               capture_press       = 1'b1;
               events.double_click = !gap_over;
            end else if (gap_over) begin
               events.single_click = cfg.event_enable[EV_SINGLE_BIT];
            end
         end
         default: begin
         end
      endcase
      // A button that does not step in this tick reports nothing.
      if (!step) events = '0;
   end

   assign level_next = step ? down : level_ff;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         level_ff <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         level_ff <= down;
      end
   end

   // Time stamps are always written before they are read.
   always_ff @(posedge clock) begin
      if (step && capture_press) press_stamp_ff <= now_ms;
      if (step && capture_release) release_stamp_ff <= now_ms;
   end

endmodule

`default_nettype wire

// ===== src/button_click_event_detector.sv =====
// Top level of the button click event detector.
//
// Usage: each request transfer on req_* is one update tick carrying a
// millisecond time stamp and the active-low levels of eight button pins.
// Every tick gives exactly one response transfer on rsp_* with masks of
// the single clicks, double clicks and long presses seen in that tick and
// the stored pressed level of each button.
// The request is registered in the input register; the per-button
// machines update from it and the response register loads at the same
// edge, when the response register is free or its response is taken.
// One tick per cycle is sustained while rsp_ready stays high; the response
// register and the input register let a new request be taken while a
// finished response waits.
// When rsp_ready is low, the response holds and the input register fills;
// req_ready then drops until the response is taken.
// Reset empties both registers, puts every button in the idle phase with
// its pressed level cleared and loads default settings. The user must write
// settings through csr_* only while no tick is in flight; no check enforces it.
`default_nettype none

module button_click_event_detector
   import bced_pkg::*;
#(
   parameter int BUTTONS = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   cfg_type     cfg_ff;
   logic [3:0]  count_ff;
   logic        in_valid_ff;
   req_type     in_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff, rsp_in;
   logic        advance;
   logic        work;

   event_type   cell_events [BUTTONS];
   logic [BUTTONS-1:0] cell_level;

   // Settings registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.event_enable  <= RST_EVENT_ENABLE;
         cfg_ff.long_press_ms <= RST_LONG_PRESS_MS;
         cfg_ff.double_gap_ms <= RST_DOUBLE_GAP_MS;
         cfg_ff.debounce_ms   <= RST_DEBOUNCE_MS;
         count_ff             <= RST_ENABLED_COUNT;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_EVENT_ENABLE:  cfg_ff.event_enable  <= csr_data[2:0];
            CSR_LONG_PRESS_MS: cfg_ff.long_press_ms <= csr_data;
            CSR_DOUBLE_GAP_MS: cfg_ff.double_gap_ms <= csr_data;
            CSR_DEBOUNCE_MS:   cfg_ff.debounce_ms   <= csr_data[7:0];
            CSR_ENABLED_COUNT: count_ff             <= csr_data[3:0];
            default: begin
            end
         endcase
      end
   end

   // Handshake: the tick moves on when the response register is free.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign work      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else if (req_ready) in_valid_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_ff <= req_data;
   end

   // One machine per button; buttons past the enabled count stay frozen and report no events.
   for (genvar i = 0; i < BUTTONS; i++) begin : g_button
      localparam logic [5:0] Index = 6'(i);
      logic enabled;
      logic down;

      assign enabled = {2'b00, count_ff} > Index;

      if (i < PINS) begin : g_pin
         assign down = !in_ff.pin_levels[i];
      end else begin : g_nopin
         assign down = 1'b0;
      end

      bced_button u_button (
         .clock      (clock),
         .reset      (reset),
         .step       (work && enabled),
         .down       (down),
         .now_ms     (in_ff.now_ms),
         .cfg        (cfg_ff),
         .events     (cell_events[i]),
         .level_next (cell_level[i])
      );
   end

   // Gather the masks of the buttons that have a pin.
   for (genvar j = 0; j < PINS; j++) begin : g_mask
      if (j < BUTTONS) begin : g_used
         assign rsp_in.click_mask[j]   = cell_events[j].single_click;
         assign rsp_in.double_mask[j]  = cell_events[j].double_click;
         assign rsp_in.long_mask[j]    = cell_events[j].long_press;
         assign rsp_in.pressed_mask[j] = cell_level[j];
      end else begin : g_unused
         assign rsp_in.click_mask[j]   = 1'b0;
         assign rsp_in.double_mask[j]  = 1'b0;
         assign rsp_in.long_mask[j]    = 1'b0;
         assign rsp_in.pressed_mask[j] = 1'b0;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (advance) rsp_valid_ff <= in_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (work) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== src/bced_checker.sv =====
// Port-level checks of the button click event detector, bound to the top level.
`default_nettype none

module bced_checker
   import bced_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire rsp_type     rsp_data
);

   // A stalled response stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // A stalled response keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("response changed while stalled");

   // Reset leaves no response in flight.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response offered right after reset");

   // Click and long press come on a release, a double click on a press.
   a_event_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (((rsp_data.click_mask | rsp_data.long_mask) & rsp_data.pressed_mask)
         == 8'd0) && ((rsp_data.double_mask & ~rsp_data.pressed_mask) == 8'd0))
      else $error("event disagrees with pressed level");

   // A button gives at most one kind of event per tick.
   a_event_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.click_mask & rsp_data.double_mask) == 8'd0)
         && ((rsp_data.click_mask & rsp_data.long_mask) == 8'd0)
         && ((rsp_data.double_mask & rsp_data.long_mask) == 8'd0))
      else $error("two events on one button in one tick");

endmodule

bind button_click_event_detector bced_checker u_bced_checker (.*);

`default_nettype wire
